>>> sv/smm_pkg.sv
// shared types and constants for the strip matrix multiply block
package smm_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 16;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 48;
    localparam int CFG_W  = 6;
    localparam int REG_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRODUCT = 2'd2;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_DIM        = 2'd0;
    localparam logic [REG_W-1:0] REG_STRIP_ROWS = 2'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] DIM_RESET        = 6'd32;
    localparam logic [CFG_W-1:0] STRIP_ROWS_RESET = 6'd32;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic issue;     // read one operand pair and advance
        logic load_out;  // move finished result into output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic             req_prod;   // in-range product request on input
        logic [CFG_W-1:0] eff_dim;    // clamped dimension
        logic             pipe_busy;  // multiply-accumulate still in flight
        logic             out_free;   // output register can load this cycle
    } t_dp_status;

endpackage

>>> sv/smm_ctrl.sv
// controller state machine for the strip matrix multiply block
module smm_ctrl #(
    parameter int MAX_DIM = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  smm_pkg::t_dp_status i_status,
    output smm_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_stall
);

    localparam int KW = $clog2(MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [KW-1:0] r_k;
    logic [KW-1:0] n_k;
    logic          accept;
    logic          last_k;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign last_k     = ((32'(r_k) + 32'd1) == 32'(i_status.eff_dim));

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = accept;
                if (accept) begin
                    n_k = '0;
                    if (i_status.req_prod) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_k         = r_k + KW'(1);
                if (last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

endmodule

>>> sv/smm_dp.sv
// datapath: config registers, element stores, multiply-accumulate, output register
module smm_dp #(
    parameter int MAX_DIM = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smm_pkg::REG_W-1:0]           i_cfg_index,
    input  logic [smm_pkg::CFG_W-1:0]           i_cfg_data,
    // input payload
    input  logic [smm_pkg::CMD_W-1:0]           i_command,
    input  logic [smm_pkg::IDX_W-1:0]           i_row,
    input  logic [smm_pkg::IDX_W-1:0]           i_col,
    input  logic signed [smm_pkg::VAL_W-1:0]    i_value,
    // output channel
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_status,
    output logic                                o_is_product,
    output logic signed [smm_pkg::PROD_W-1:0]   o_product,
    // controller link
    input  smm_pkg::t_dp_cmd                    i_cmd,
    output smm_pkg::t_dp_status                 o_status_bus
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [smm_pkg::CFG_W-1:0] r_dim;
    logic [smm_pkg::CFG_W-1:0] r_strip_rows;
    logic [smm_pkg::CFG_W-1:0] eff_dim;
    logic [smm_pkg::CFG_W-1:0] eff_rows;
    logic [smm_pkg::CFG_W-1:0] row_ext;
    logic [smm_pkg::CFG_W-1:0] col_ext;
    logic                      ok_a;
    logic                      ok_b;
    logic                      ok;
    logic                      req_prod;
    logic                      wr_a;
    logic                      wr_b;
    logic [ADDR_W-1:0]         wr_addr;

    logic [smm_pkg::VAL_W-1:0] strip_mem  [DEPTH];
    logic [smm_pkg::VAL_W-1:0] square_mem [DEPTH];

    logic [ADDR_W-1:0]                r_a_addr;
    logic [ADDR_W-1:0]                r_b_addr;
    logic signed [smm_pkg::VAL_W-1:0] r_a_q;
    logic signed [smm_pkg::VAL_W-1:0] r_b_q;
    logic                             r_rd_vld;
    logic signed [smm_pkg::MUL_W-1:0] r_mul;
    logic                             r_mul_vld;
    logic signed [smm_pkg::PROD_W-1:0] r_acc;
    logic                             r_res_status;
    logic                             r_res_is_prod;
    logic                             r_out_valid;
    logic                             out_free;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim        <= smm_pkg::DIM_RESET;
            r_strip_rows <= smm_pkg::STRIP_ROWS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == smm_pkg::REG_DIM) begin
                r_dim <= i_cfg_data;
            end else if (i_cfg_index == smm_pkg::REG_STRIP_ROWS) begin
                r_strip_rows <= i_cfg_data;
            end
        end
    end

    // clamp register values to the store size
    assign eff_dim  = (32'(r_dim) > MAX_DIM) ? smm_pkg::CFG_W'(MAX_DIM) : r_dim;
    assign eff_rows = (32'(r_strip_rows) > MAX_DIM) ? smm_pkg::CFG_W'(MAX_DIM)
                                                     : r_strip_rows;

    // range checks per command
    assign row_ext = smm_pkg::CFG_W'(i_row);
    assign col_ext = smm_pkg::CFG_W'(i_col);
    assign ok_a    = (row_ext < eff_rows) && (col_ext < eff_dim);
    assign ok_b    = (row_ext < eff_dim) && (col_ext < eff_dim);

    always_comb begin
        case (i_command)
            smm_pkg::CMD_WRITE_A: ok = ok_a;
            smm_pkg::CMD_WRITE_B: ok = ok_b;
            smm_pkg::CMD_PRODUCT: ok = ok_a;
            default:              ok = 1'b0;
        endcase
    end

    assign req_prod = ok && (i_command == smm_pkg::CMD_PRODUCT);
    assign wr_a     = i_cmd.accept && ok && (i_command == smm_pkg::CMD_WRITE_A);
    assign wr_b     = i_cmd.accept && ok && (i_command == smm_pkg::CMD_WRITE_B);
    assign wr_addr  = ADDR_W'(32'(i_row) * MAX_DIM + 32'(i_col));

    // strip store: A elements
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            strip_mem[wr_addr] <= i_value;
        end
        r_a_q <= strip_mem[r_a_addr];
    end

    // square store: B elements
    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            square_mem[wr_addr] <= i_value;
        end
        r_b_q <= square_mem[r_b_addr];
    end

    // operand address walk: along the A row, down the B column
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a_addr <= ADDR_W'(32'(i_row) * MAX_DIM);
            r_b_addr <= ADDR_W'(i_col);
        end else if (i_cmd.issue) begin
            r_a_addr <= r_a_addr + ADDR_W'(1);
            r_b_addr <= r_b_addr + ADDR_W'(MAX_DIM);
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.issue;
            r_mul_vld <= r_rd_vld;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_mul <= r_a_q * r_b_q;
    end

    // accumulate stage and result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc         <= '0;
            r_res_status  <= !ok;
            r_res_is_prod <= req_prod;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + smm_pkg::PROD_W'(r_mul);
        end
    end

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status     <= r_res_status;
            o_is_product <= r_res_is_prod;
            o_product    <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;

    // status back to the controller
    assign o_status_bus.req_prod  = req_prod;
    assign o_status_bus.eff_dim   = eff_dim;
    assign o_status_bus.pipe_busy = r_rd_vld || r_mul_vld;
    assign o_status_bus.out_free  = out_free;

endmodule

>>> sv/strip_matrix_multiply_top.sv
// top level of the strip matrix multiply block
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------------
//  input     | in        | i_in_valid / o_in_stall     | i_command i_row i_col i_value
//  result    | out       | o_out_valid / i_out_stall   | o_status o_is_product o_product
//  config    | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index i_cfg_data
//
// a write or a rejected item is accepted, then loaded into the output register
// a product request is accepted, then makes dim operand reads through the one
// multiply-accumulate unit, drains the read, multiply and accumulate stages,
// and loads the output register
// synchronous active-low reset sets dim and strip_rows to 32; the stores are not cleared
// a held result does not block the next item, whose result waits until the output
// register is free, with the input stalled meanwhile
module strip_matrix_multiply_top #(
    parameter int MAX_DIM = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [smm_pkg::CMD_W-1:0]           i_command,
    input  logic [smm_pkg::IDX_W-1:0]           i_row,
    input  logic [smm_pkg::IDX_W-1:0]           i_col,
    input  logic signed [smm_pkg::VAL_W-1:0]    i_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_status,
    output logic                                o_is_product,
    output logic signed [smm_pkg::PROD_W-1:0]   o_product,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smm_pkg::REG_W-1:0]           i_cfg_index,
    input  logic [smm_pkg::CFG_W-1:0]           i_cfg_data
);

    smm_pkg::t_dp_cmd    dp_cmd;
    smm_pkg::t_dp_status dp_status;

    // sequencer
    smm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // stores and arithmetic
    smm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_is_product (o_is_product),
        .o_product    (o_product),
        .i_cmd        (dp_cmd),
        .o_status_bus (dp_status)
    );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the strip matrix multiply block
module tb_top;

    localparam int MAX_DIM     = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = MAX_DIM + 8;
    localparam int NUM_PHASES  = 12;

    // widths and codes taken from the package
    localparam int CMD_W  = smm_pkg::CMD_W;
    localparam int IDX_W  = smm_pkg::IDX_W;
    localparam int VAL_W  = smm_pkg::VAL_W;
    localparam int PROD_W = smm_pkg::PROD_W;
    localparam int CFG_W  = smm_pkg::CFG_W;
    localparam int REG_W  = smm_pkg::REG_W;
    localparam logic [CMD_W-1:0] CMD_WRITE_A      = smm_pkg::CMD_WRITE_A;
    localparam logic [CMD_W-1:0] CMD_WRITE_B      = smm_pkg::CMD_WRITE_B;
    localparam logic [CMD_W-1:0] CMD_PRODUCT      = smm_pkg::CMD_PRODUCT;
    localparam logic [REG_W-1:0] REG_DIM          = smm_pkg::REG_DIM;
    localparam logic [REG_W-1:0] REG_STRIP_ROWS   = smm_pkg::REG_STRIP_ROWS;
    localparam logic [CFG_W-1:0] DIM_RESET        = smm_pkg::DIM_RESET;
    localparam logic [CFG_W-1:0] STRIP_ROWS_RESET = smm_pkg::STRIP_ROWS_RESET;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [REG_W-1:0] REG_UNUSED  = 2'd3;

    // per-phase register settings, small sizes mostly, extremes included
    localparam int PHASE_DIM  [NUM_PHASES] = '{4, 1, 2, 8, 3, 40, 5, 32, 6, 0, 7, 3};
    localparam int PHASE_ROWS [NUM_PHASES] = '{3, 1, 32, 2, 5, 2, 4, 1, 63, 3, 0, 6};

    typedef struct packed {
        logic              status;
        logic              is_product;
        logic [PROD_W-1:0] product;
    } t_result;

    typedef struct packed {
        bit                is_cfg;
        logic [REG_W-1:0]  reg_idx;
        logic [CFG_W-1:0]  reg_data;
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        bit                typed;
        logic              exp_status;
        logic              exp_is_product;
        logic [PROD_W-1:0] exp_product;
    } t_plan_step;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [CMD_W-1:0]          i_command;
    logic [IDX_W-1:0]          i_row;
    logic [IDX_W-1:0]          i_col;
    logic signed [VAL_W-1:0]   i_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_status;
    logic                      o_is_product;
    logic signed [PROD_W-1:0]  o_product;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [REG_W-1:0]          i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;

    // mirror of the block: both stores, which entries hold data, and the registers
    logic [VAL_W-1:0] strip_mirror   [MAX_DIM][MAX_DIM];
    logic [VAL_W-1:0] square_mirror  [MAX_DIM][MAX_DIM];
    bit               strip_written  [MAX_DIM][MAX_DIM];
    bit               square_written [MAX_DIM][MAX_DIM];
    logic [CFG_W-1:0] dim_reg  = DIM_RESET;
    logic [CFG_W-1:0] rows_reg = STRIP_ROWS_RESET;

    t_result outstanding_results [$];
    int      result_errors = 0;
    bit      quiet_stretch = 1'b0;
    bit      hold_trigger  = 1'b0;

    // directed steps: register writes interleaved with transactions
    t_plan_step directed_plan [33] = '{
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd31, 5'd31, 16'h7fff, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd31, 5'd31, 16'h8000, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_UNKNOWN, 5'd31, 5'd0, 16'h1234, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b1, REG_DIM, 6'd1, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b1, REG_STRIP_ROWS, 6'd1, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0,
          1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd0, 5'd0, 16'h8000, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd0, 5'd0, 16'h8000, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd0, 5'd0, 16'h0000, 1'b1, 1'b0, 1'b1,
          48'd1073741824},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd0, 5'd0, 16'h7fff, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b1, REG_UNUSED, 6'd63, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0,
          1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd0, 5'd0, 16'hffff, 1'b1, 1'b0, 1'b1,
          -48'sd1073709056},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd1, 5'd0, 16'h0001, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd0, 5'd1, 16'h0001, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd0, 5'd1, 16'h0000, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd1, 5'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd0, 5'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd0, 5'd0, 16'h0000, 1'b1, 1'b0, 1'b1, 48'd0},
        '{1'b1, REG_DIM, 6'd0, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd0, 5'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd0, 5'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b1, REG_DIM, 6'd63, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b1, REG_STRIP_ROWS, 6'd63, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0,
          1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd31, 5'd30, 16'h0000, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd30, 5'd31, 16'hffff, 1'b1, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_UNKNOWN, 5'd31, 5'd31, 16'hffff, 1'b1, 1'b1, 1'b0, 48'd0},
        '{1'b1, REG_DIM, 6'd2, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b1, REG_STRIP_ROWS, 6'd2, CMD_WRITE_A, 5'd0, 5'd0, 16'h0000, 1'b0,
          1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd1, 5'd0, 16'h0180, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_A, 5'd1, 5'd1, 16'hfe00, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd0, 5'd1, 16'h0300, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_WRITE_B, 5'd1, 5'd1, 16'h0040, 1'b0, 1'b0, 1'b0, 48'd0},
        '{1'b0, REG_DIM, 6'd0, CMD_PRODUCT, 5'd1, 5'd1, 16'h0000, 1'b0, 1'b0, 1'b0, 48'd0}
    };

    strip_matrix_multiply_top #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_is_product (o_is_product),
        .o_product    (o_product),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // register values above the largest size act as the largest size
    function automatic int eff_size(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // expected result of one transaction, updating the mirrored stores
    function automatic t_result apply_matrix_item(input logic [CMD_W-1:0] cmd,
                                                  input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col,
                                                  input logic [VAL_W-1:0] val);
        t_result res;
        int      n;
        int      rows;
        int      k;
        longint  acc;
        res        = '0;
        res.status = 1'b1;
        n          = eff_size(dim_reg);
        rows       = eff_size(rows_reg);
        case (cmd)
            CMD_WRITE_A: begin
                if (row < rows && col < n) begin
                    strip_mirror[row][col]  = val;
                    strip_written[row][col] = 1'b1;
                    res.status              = 1'b0;
                end
            end
            CMD_WRITE_B: begin
                if (row < n && col < n) begin
                    square_mirror[row][col]  = val;
                    square_written[row][col] = 1'b1;
                    res.status               = 1'b0;
                end
            end
            CMD_PRODUCT: begin
                if (row < rows && col < n) begin
                    // exact dot product of the strip row with the square column
                    acc = 0;
                    for (k = 0; k < n; k++) begin
                        acc += longint'($signed(strip_mirror[row][k]))
                             * longint'($signed(square_mirror[k][col]));
                    end
                    res.status     = 1'b0;
                    res.is_product = 1'b1;
                    res.product    = acc[PROD_W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // random transaction: mostly in-range writes and products whose operands are filled in
    task automatic pick_random_item(output logic [CMD_W-1:0] cmd,
                                    output logic [IDX_W-1:0] row,
                                    output logic [IDX_W-1:0] col,
                                    output logic [VAL_W-1:0] val);
        int n;
        int rows;
        int sel;
        int k;
        int pr_row;
        int pr_col;
        bit found;
        n    = eff_size(dim_reg);
        rows = eff_size(rows_reg);
        sel  = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       val = 16'h8000;
            1:       val = 16'h7fff;
            2:       val = 16'h0000;
            default: val = 16'($urandom);
        endcase
        if (sel < 40 && n > 0 && rows > 0) begin
            if ($urandom_range(0, 1) == 0) begin
                cmd = CMD_WRITE_A;
                row = IDX_W'($urandom_range(0, rows - 1));
            end else begin
                cmd = CMD_WRITE_B;
                row = IDX_W'($urandom_range(0, n - 1));
            end
            col = IDX_W'($urandom_range(0, n - 1));
        end else begin
            if (sel < 80 && n > 0 && rows > 0) begin
                cmd = CMD_PRODUCT;
                row = IDX_W'($urandom_range(0, rows - 1));
                col = IDX_W'($urandom_range(0, n - 1));
            end else begin
                // noise: any command and any index
                cmd = CMD_W'($urandom_range(0, 3));
                row = IDX_W'($urandom);
                col = IDX_W'($urandom);
            end
            // an in-range product first gets every operand it reads written
            if (cmd == CMD_PRODUCT && row < rows && col < n) begin
                pr_row = row;
                pr_col = col;
                found  = 1'b0;
                for (k = 0; k < n && !found; k++) begin
                    if (!strip_written[pr_row][k]) begin
                        cmd   = CMD_WRITE_A;
                        col   = IDX_W'(k);
                        found = 1'b1;
                    end
                end
                for (k = 0; k < n && !found; k++) begin
                    if (!square_written[k][pr_col]) begin
                        cmd   = CMD_WRITE_B;
                        row   = IDX_W'(k);
                        found = 1'b1;
                    end
                end
            end
        end
    endtask

    // offer one transaction, record its expected result once taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val,
                             input bit typed, input t_result typed_result);
        t_result predicted;
        int      gap;
        @(negedge i_clk);
        if (!quiet_stretch && $urandom_range(0, 99) < 8) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_row      <= row;
        i_col      <= col;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_matrix_item(cmd, row, col, val);
        outstanding_results.push_back(typed ? typed_result : predicted);
    endtask

    // stop offering and wait for every outstanding result
    task automatic await_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding_results.size() != 0) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_register(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
        await_all_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DIM:        dim_reg  = data;
            REG_STRIP_ROWS: rows_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result-side stall: random, none during quiet stretches, one long hold-off
    initial begin : result_stall_gen
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_stretch) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 8);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_is_product, o_product};
            if (outstanding_results.size() == 0) begin
                result_errors++;
                if (result_errors <= 10)
                    $display("unexpected result: status %0d is_product %0d product %0d",
                             got.status, got.is_product, $signed(got.product));
            end else begin
                want = outstanding_results.pop_front();
                if (got.status !== want.status || got.is_product !== want.is_product ||
                    got.product !== want.product) begin
                    result_errors++;
                    if (result_errors <= 10)
                        $display({"result mismatch: expected status %0d is_product %0d ",
                                  "product %0d, got status %0d is_product %0d product %0d"},
                                 want.status, want.is_product, $signed(want.product),
                                 got.status, got.is_product, $signed(got.product));
                end
            end
        end
    end

    // end the run if no transaction moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus: reset, directed steps, then random phases
    initial begin : stimulus
        int               p;
        int               i;
        int               count;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_WRITE_A;
        i_row       = '0;
        i_col       = '0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_DIM;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[s]) begin
            if (directed_plan[s].is_cfg)
                write_register(directed_plan[s].reg_idx, directed_plan[s].reg_data);
            else
                send_item(directed_plan[s].cmd, directed_plan[s].row, directed_plan[s].col,
                          directed_plan[s].value, directed_plan[s].typed,
                          {directed_plan[s].exp_status, directed_plan[s].exp_is_product,
                           directed_plan[s].exp_product});
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            write_register(REG_DIM, CFG_W'(PHASE_DIM[p]));
            write_register(REG_STRIP_ROWS, CFG_W'(PHASE_ROWS[p]));
            quiet_stretch = (p == 2);
            count = (PHASE_DIM[p] >= MAX_DIM) ? 100 : 56;
            for (i = 0; i < count; i++) begin
                // long receiver hold-off while the sender keeps offering
                if (p == 4 && i == 10)
                    hold_trigger = 1'b1;
                // sender pause until the block has drained
                if (p == 6 && i == 20)
                    await_all_results();
                pick_random_item(cmd, row, col, val);
                send_item(cmd, row, col, val, 1'b0, '0);
            end
        end

        await_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (result_errors == 0 && outstanding_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
sv/smm_pkg.sv
sv/smm_ctrl.sv
sv/smm_dp.sv
sv/strip_matrix_multiply_top.sv
tb/tb_top.sv
